@@ rtl/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and character classification for the base64
// stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	// Depth of the run queue between the front and back parts.
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	// Configuration register indexes.
	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t CFG_ALPHABET = 2'd0;
	localparam cfg_index_t CFG_PADDING  = 2'd1;
	localparam cfg_index_t CFG_STRICT   = 2'd2;

	// Character codes.
	localparam logic [7:0] CHR_UPPER_A = 8'h41;
	localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHR_LOWER_A = 8'h61;
	localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
	localparam logic [7:0] CHR_PAD     = 8'h3D;
	localparam logic [7:0] CHR_PLUS    = 8'h2B;
	localparam logic [7:0] CHR_SLASH   = 8'h2F;
	localparam logic [7:0] CHR_MINUS   = 8'h2D;
	localparam logic [7:0] CHR_UNDER   = 8'h5F;
	localparam logic [7:0] CHR_SPACE   = 8'h20;
	localparam logic [7:0] CHR_TAB     = 8'h09;
	localparam logic [7:0] CHR_LF      = 8'h0A;
	localparam logic [7:0] CHR_CR      = 8'h0D;

	// One configuration write.
	typedef struct packed {
		logic       valid;
		cfg_index_t index;
		logic       data;
	} cfg_wr_t;

	// Class of one input character.
	typedef struct packed {
		logic [5:0] sextet;
		logic       is_pad;
		logic       is_bad;
	} cls_t;

	// All results caused by one input word: up to three data bytes, then
	// an optional status.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      nbytes;
		logic            has_status;
		logic            ok;
	} run_t;

	// Whitespace that non-strict mode skips.
	function automatic logic b64d_blank(input logic [7:0] c);
		return (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_LF) || (c == CHR_CR);
	endfunction

	// Map a character to its sextet, padding or invalid class.
	function automatic cls_t b64d_classify(input logic [7:0] c, input logic url);
		cls_t r;
		r = '0;
		if (c inside {[CHR_UPPER_A:CHR_UPPER_Z]}) begin
			r.sextet = 6'(c - CHR_UPPER_A);
		end else if (c inside {[CHR_LOWER_A:CHR_LOWER_Z]}) begin
			r.sextet = 6'(c - CHR_LOWER_A + 8'd26);
		end else if (c inside {[CHR_DIGIT_0:CHR_DIGIT_9]}) begin
			r.sextet = 6'(c - CHR_DIGIT_0 + 8'd52);
		end else if (c == CHR_PAD) begin
			r.is_pad = 1'b1;
		end else if (!url && c == CHR_PLUS) begin
			r.sextet = 6'd62;
		end else if (!url && c == CHR_SLASH) begin
			r.sextet = 6'd63;
		end else if (url && c == CHR_MINUS) begin
			r.sextet = 6'd62;
		end else if (url && c == CHR_UNDER) begin
			r.sextet = 6'd63;
		end else begin
			r.is_bad = 1'b1;
		end
		return r;
	endfunction

endpackage

@@ rtl/base64_stream_decoder_core.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Base64 (standard or url-safe) stream decoder with a final status word.
// ----------------------------------------------------------------------------
// One character is accepted per clock while full is low; the character is
// classified and folded into the quad state in the cycle it is accepted, and
// the words it causes (up to three data bytes and, at end of string, one
// status word) go as one run into a four-run queue. The back part delivers one
// result word per cycle while pop is high and a run is waiting, and full rises
// only when four runs are waiting. Data bytes of a string are provisional until
// its status word: on decode_ok low the consumer drops them. Configuration
// writes are always ready and take effect at once; the user must make them only
// while the block is idle, which the block itself does not enforce.
module base64_stream_decoder_core import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_in,
	input  logic       end_of_string,
	output logic       empty,
	input  logic       pop,
	output logic       is_status,
	output logic [7:0] data_byte,
	output logic       decode_ok,
	output logic       last_of_run
);

	cfg_wr_t cfg_wr;
	logic    accept;
	logic    run_push;
	run_t    run_in;
	run_t    run_out;
	logic    run_pop;
	logic    fifo_empty;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;
	assign accept       = push && !full;

	// Front: classification and quad state.
	b64d_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr        (cfg_wr),
		.accept        (accept),
		.char_in       (char_in),
		.end_of_string (end_of_string),
		.run_push      (run_push),
		.run           (run_in)
	);

	// Queue of pending runs.
	b64d_run_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (run_push),
		.wr_data (run_in),
		.rd_en   (run_pop),
		.rd_data (run_out),
		.full    (full),
		.empty   (fifo_empty)
	);

	// Back: result delivery.
	b64d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_data   (run_out),
		.fifo_empty  (fifo_empty),
		.fifo_pop    (run_pop),
		.pop         (pop),
		.empty       (empty),
		.is_status   (is_status),
		.data_byte   (data_byte),
		.decode_ok   (decode_ok),
		.last_of_run (last_of_run)
	);

endmodule

@@ rtl/b64d_front.sv @@
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them, tracks the quad state and builds the
// run of results that each character causes.
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_wr_t    cfg_wr,
	input  logic       accept,
	input  logic [7:0] char_in,
	input  logic       end_of_string,
	output logic       run_push,
	output run_t       run
);

	logic        alphabet_q;
	logic        padreq_q;
	logic        strict_q;
	logic [17:0] hold_q;
	logic [1:0]  pos_q;
	logic        pad3_q;
	logic        pdone_q;
	logic        fail_q;

	logic [17:0] hold_d;
	logic [1:0]  pos_d;
	logic        pad3_d;
	logic        pdone_d;
	logic        fail_d;
	logic        skip;
	cls_t        cls;
	run_t        run_d;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_q <= 1'b0;
			padreq_q   <= 1'b0;
			strict_q   <= 1'b0;
		end else if (cfg_wr.valid) begin
			case (cfg_wr.index)
				CFG_ALPHABET: alphabet_q <= cfg_wr.data;
				CFG_PADDING:  padreq_q   <= cfg_wr.data;
				CFG_STRICT:   strict_q   <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	// Next quad state and the run for the current character.
	always_comb begin
		cls     = b64d_classify(char_in, alphabet_q);
		skip    = !strict_q && b64d_blank(char_in);
		hold_d  = hold_q;
		pos_d   = pos_q;
		pad3_d  = pad3_q;
		pdone_d = pdone_q;
		fail_d  = fail_q;
		run_d   = '0;

		if (!skip && !fail_q) begin
			if (pdone_q || cls.is_bad) begin
				fail_d = 1'b1;
			end else if (pos_q < 2'd2) begin
				if (cls.is_pad) begin
					fail_d = 1'b1;
				end else begin
					hold_d = {hold_q[11:0], cls.sextet};
					pos_d  = pos_q + 2'd1;
				end
			end else if (pos_q == 2'd2) begin
				if (cls.is_pad) begin
					pad3_d = 1'b1;
				end else begin
					hold_d = {hold_q[11:0], cls.sextet};
				end
				pos_d = 2'd3;
			end else begin
				// Fourth character closes the quad.
				if (pad3_q) begin
					if (cls.is_pad) begin
						run_d.bytes[0] = hold_q[11:4];
						run_d.nbytes   = 2'd1;
						pdone_d        = 1'b1;
					end else begin
						fail_d = 1'b1;
					end
				end else if (cls.is_pad) begin
					run_d.bytes[0] = hold_q[17:10];
					run_d.bytes[1] = hold_q[9:2];
					run_d.nbytes   = 2'd2;
					pdone_d        = 1'b1;
				end else begin
					run_d.bytes[0] = hold_q[17:10];
					run_d.bytes[1] = hold_q[9:2];
					run_d.bytes[2] = {hold_q[1:0], cls.sextet};
					run_d.nbytes   = 2'd3;
				end
				hold_d = '0;
				pos_d  = 2'd0;
				pad3_d = 1'b0;
			end
		end

		// End of string: flush an unpadded tail and append the status.
		if (end_of_string) begin
			if (!fail_d) begin
				if (pad3_d || pos_d == 2'd1) begin
					fail_d = 1'b1;
				end else if (pos_d >= 2'd2 && padreq_q) begin
					fail_d = 1'b1;
				end else if (pos_d == 2'd2) begin
					run_d.bytes[0] = hold_d[11:4];
					run_d.nbytes   = 2'd1;
				end else if (pos_d == 2'd3) begin
					run_d.bytes[0] = hold_d[17:10];
					run_d.bytes[1] = hold_d[9:2];
					run_d.nbytes   = 2'd2;
				end
			end
			run_d.has_status = 1'b1;
			run_d.ok         = !fail_d;
			hold_d  = '0;
			pos_d   = 2'd0;
			pad3_d  = 1'b0;
			pdone_d = 1'b0;
			fail_d  = 1'b0;
		end
	end

	// Quad state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= '0;
			pos_q   <= 2'd0;
			pad3_q  <= 1'b0;
			pdone_q <= 1'b0;
			fail_q  <= 1'b0;
		end else if (accept) begin
			hold_q  <= hold_d;
			pos_q   <= pos_d;
			pad3_q  <= pad3_d;
			pdone_q <= pdone_d;
			fail_q  <= fail_d;
		end
	end

	assign run      = run_d;
	assign run_push = accept && (run_d.nbytes != 2'd0 || end_of_string);

	// A pushed run without status always carries data.
	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		run_push && !run.has_status |-> run.nbytes != 2'd0)
		else $error("empty run pushed");

	// A failed string produces no data until its end.
	a_fail_absorbs: assert property (@(posedge clk) disable iff (!arst_n)
		fail_q && accept && !end_of_string |-> !run_push)
		else $error("data after failure");

endmodule

@@ rtl/b64d_run_fifo.sv @@
// ----------------------------------------------------------------------------
// b64d_run_fifo
// Short queue of result runs between the front and back parts.
// ----------------------------------------------------------------------------
module b64d_run_fifo import b64d_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  run_t wr_data,
	input  logic rd_en,
	output run_t rd_data,
	output logic full,
	output logic empty
);

	run_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;

	// Storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (FIFO_AW+1)'(1);
				2'b01:   count_q <= count_q - (FIFO_AW+1)'(1);
				default: ;
			endcase
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign full    = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty   = (count_q == '0);

	// Fill count stays within the depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("fifo count out of range");

	// No write into a full queue and no read from an empty one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full) && !(rd_en && empty))
		else $error("fifo overflow or underflow");

endmodule

@@ rtl/b64d_back.sv @@
// ----------------------------------------------------------------------------
// b64d_back
// Takes runs from the queue and delivers their results one word at a time.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  run_t       fifo_data,
	input  logic       fifo_empty,
	output logic       fifo_pop,
	input  logic       pop,
	output logic       empty,
	output logic       is_status,
	output logic [7:0] data_byte,
	output logic       decode_ok,
	output logic       last_of_run
);

	run_t       cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;

	logic [2:0] total;
	logic       last;
	logic       advance;
	logic       load;

	// Position within the current run.
	assign total   = {1'b0, cur_q.nbytes} + {2'b00, cur_q.has_status};
	assign last    = ({1'b0, idx_q} == total - 3'd1);
	assign advance = cur_valid_q && pop;
	assign load    = (!cur_valid_q || (advance && last)) && !fifo_empty;
	assign fifo_pop = load;

	// Current run register.
	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= fifo_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (load) begin
			cur_valid_q <= 1'b1;
			idx_q       <= 2'd0;
		end else if (advance) begin
			if (last) begin
				cur_valid_q <= 1'b0;
			end
			idx_q <= idx_q + 2'd1;
		end
	end

	// Result word selection.
	always_comb begin
		is_status = (idx_q == cur_q.nbytes);
		case (idx_q)
			2'd0:    data_byte = cur_q.bytes[0];
			2'd1:    data_byte = cur_q.bytes[1];
			2'd2:    data_byte = cur_q.bytes[2];
			default: data_byte = 8'h00;
		endcase
		if (is_status) begin
			data_byte = 8'h00;
		end
	end

	assign decode_ok   = is_status && cur_q.ok;
	assign last_of_run = last;
	assign empty       = !cur_valid_q;

	// The index never runs past the end of the current run.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> ({1'b0, idx_q} < total))
		else $error("run index out of range");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for base64_stream_decoder_core. It opens with a short
// table of hand-picked characters, then sends random strings under every
// register setting. Most strings are well-formed encodings, some are
// corrupted, and some are random bytes. Every accepted character is run
// through a local decoder model. Each result word the block delivers is
// compared field by field with the oldest word that the model predicts.
// ----------------------------------------------------------------------------
module testbench import b64d_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;
	localparam int IDLE_PCT    = 34;
	localparam int PHASE_CHARS = 8;
	localparam int DRAIN_WAIT  = 8;
	localparam int MAX_REPORTS = 10;

	// Symbol classes beyond the 64 sextet values.
	localparam logic [6:0] SYM_PAD = 7'd64;
	localparam logic [6:0] SYM_BAD = 7'd65;

	// One result word as the block presents it.
	typedef struct packed {
		logic       st;
		logic [7:0] data;
		logic       ok;
		logic       last;
	} out_word_t;

	// One row of the directed table. When typed is set, the row must give exactly
	// one status word with the ok bit shown.
	typedef struct packed {
		logic [7:0] chr;
		logic       eos;
		logic       typed;
		logic       ok;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic       cfg_data = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] char_in = '0;
	logic       end_of_string = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic       is_status;
	logic [7:0] data_byte;
	logic       decode_ok;
	logic       last_of_run;

	base64_stream_decoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.char_in      (char_in),
		.end_of_string(end_of_string),
		.empty        (empty),
		.pop          (pop),
		.is_status    (is_status),
		.data_byte    (data_byte),
		.decode_ok    (decode_ok),
		.last_of_run  (last_of_run)
	);

	always #4 clk = ~clk;

	// Decoder model: register copy and string state.
	logic        cfg_url;
	logic        cfg_need_pad;
	logic        cfg_strict;
	logic [17:0] quad_bits;
	logic [1:0]  quad_pos;
	logic        third_pad;
	logic        pad_quad_seen;
	logic        str_failed;

	out_word_t   run_words[$];
	out_word_t   pending_words[$];
	logic [7:0]  str_chars[$];

	int errors = 0;
	int stall_cycles = 0;
	int n_chars = 0;
	int n_words = 0;
	int n_strings = 0;
	int n_bad_strings = 0;
	int n_settings = 0;
	bit calm = 1'b0;
	int hold_asks = 0;
	int hold_done = 0;
	int hold_left = 0;

	function automatic logic is_blank(input logic [7:0] c);
		return c == CHR_SPACE || c == CHR_TAB || c == CHR_LF || c == CHR_CR;
	endfunction

	// Character to sextet, or to the padding or invalid class.
	function automatic logic [6:0] sym_of(input logic [7:0] c);
		if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) return 7'(c - CHR_UPPER_A);
		if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) return 7'(c - CHR_LOWER_A + 8'd26);
		if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9) return 7'(c - CHR_DIGIT_0 + 8'd52);
		if (c == CHR_PAD) return SYM_PAD;
		if (!cfg_url && c == CHR_PLUS) return 7'd62;
		if (!cfg_url && c == CHR_SLASH) return 7'd63;
		if (cfg_url && c == CHR_MINUS) return 7'd62;
		if (cfg_url && c == CHR_UNDER) return 7'd63;
		return SYM_BAD;
	endfunction

	// Sextet to character in the selected alphabet.
	function automatic logic [7:0] char_of(input logic [5:0] v);
		if (v < 6'd26) return CHR_UPPER_A + 8'(v);
		if (v < 6'd52) return CHR_LOWER_A + 8'(v - 6'd26);
		if (v < 6'd62) return CHR_DIGIT_0 + 8'(v - 6'd52);
		if (v == 6'd62) return cfg_url ? CHR_MINUS : CHR_PLUS;
		return cfg_url ? CHR_UNDER : CHR_SLASH;
	endfunction

	task automatic add_byte(input logic [7:0] b);
		out_word_t w;
		w = '{st: 1'b0, data: b, ok: 1'b0, last: 1'b0};
		run_words = {run_words, w};
	endtask

	task automatic clear_string();
		quad_bits = '0;
		quad_pos = '0;
		third_pad = 1'b0;
		pad_quad_seen = 1'b0;
		str_failed = 1'b0;
	endtask

	// Decodes one character and leaves the words it causes in run_words.
	task automatic decode_char(input logic [7:0] c, input logic eos);
		logic [6:0]  sym;
		logic [23:0] t;
		out_word_t   w;
		run_words.delete();
		if (!(!cfg_strict && is_blank(c)) && !str_failed) begin
			sym = sym_of(c);
			if (pad_quad_seen || sym == SYM_BAD) begin
				str_failed = 1'b1;
			end else if (quad_pos < 2'd2) begin
				if (sym == SYM_PAD) begin
					str_failed = 1'b1;
				end else begin
					quad_bits = {quad_bits[11:0], sym[5:0]};
					quad_pos = quad_pos + 2'd1;
				end
			end else if (quad_pos == 2'd2) begin
				if (sym == SYM_PAD) third_pad = 1'b1;
				else quad_bits = {quad_bits[11:0], sym[5:0]};
				quad_pos = 2'd3;
			end else begin
				if (third_pad) begin
					if (sym == SYM_PAD) begin
						add_byte(8'(quad_bits >> 4));
						pad_quad_seen = 1'b1;
					end else begin
						str_failed = 1'b1;
					end
				end else if (sym == SYM_PAD) begin
					t = {quad_bits, 6'd0};
					add_byte(t[23:16]);
					add_byte(t[15:8]);
					pad_quad_seen = 1'b1;
				end else begin
					t = {quad_bits, sym[5:0]};
					add_byte(t[23:16]);
					add_byte(t[15:8]);
					add_byte(t[7:0]);
				end
				quad_bits = '0;
				quad_pos = '0;
				third_pad = 1'b0;
			end
		end
		// End of string: flush the tail, then the status word.
		if (eos) begin
			if (!str_failed) begin
				if (third_pad || quad_pos == 2'd1) begin
					str_failed = 1'b1;
				end else if (quad_pos >= 2'd2 && cfg_need_pad) begin
					str_failed = 1'b1;
				end else if (quad_pos == 2'd2) begin
					add_byte(8'(quad_bits >> 4));
				end else if (quad_pos == 2'd3) begin
					t = {quad_bits, 6'd0};
					add_byte(t[23:16]);
					add_byte(t[15:8]);
				end
			end
			w = '{st: 1'b1, data: 8'd0, ok: !str_failed, last: 1'b0};
			run_words = {run_words, w};
			n_strings++;
			if (str_failed) n_bad_strings++;
			clear_string();
		end
		if (run_words.size() > 0) run_words[run_words.size() - 1].last = 1'b1;
	endtask

	// Offers one character word and waits until the block takes it.
	task automatic send_char(input logic [7:0] c, input logic eos,
			input logic typed, input logic typed_ok);
		out_word_t w;
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		char_in = c;
		end_of_string = eos;
		do @(posedge clk); while (full);
		n_chars++;
		decode_char(c, eos);
		if (typed) begin
			w = '{st: 1'b1, data: 8'd0, ok: typed_ok, last: 1'b1};
			run_words.delete();
			run_words = {run_words, w};
		end
		pending_words = {pending_words, run_words};
	endtask

	task automatic send_string();
		for (int i = 0; i < str_chars.size(); i++)
			send_char(str_chars[i], i == str_chars.size() - 1, 1'b0, 1'b0);
	endtask

	// Builds a proper encoding of random bytes, with optional whitespace and
	// optional padding of the tail.
	task automatic build_encoded(input int nbytes, input bit with_pad, input int ws_pct);
		logic [7:0]  raw[$];
		logic [23:0] t;
		logic [7:0]  enc[$];
		int          rem;
		raw.delete();
		enc.delete();
		str_chars.delete();
		for (int i = 0; i < nbytes; i++) raw = {raw, 8'($urandom_range(0, 255))};
		for (int i = 0; i < nbytes; i += 3) begin
			rem = nbytes - i;
			t = {raw[i], rem > 1 ? raw[i + 1] : 8'd0, rem > 2 ? raw[i + 2] : 8'd0};
			enc = {enc, char_of(t[23:18])};
			enc = {enc, char_of(t[17:12])};
			if (rem > 1) enc = {enc, char_of(t[11:6])};
			else if (with_pad) enc = {enc, CHR_PAD};
			if (rem > 2) enc = {enc, char_of(t[5:0])};
			else if (with_pad) enc = {enc, CHR_PAD};
		end
		foreach (enc[i]) begin
			if ($urandom_range(0, 99) < ws_pct) begin
				case ($urandom_range(0, 3))
					0: str_chars = {str_chars, CHR_SPACE};
					1: str_chars = {str_chars, CHR_TAB};
					2: str_chars = {str_chars, CHR_LF};
					default: str_chars = {str_chars, CHR_CR};
				endcase
			end
			str_chars = {str_chars, enc[i]};
		end
		// No bytes: a lone blank stands for the whole string.
		if (str_chars.size() == 0) str_chars = {str_chars, CHR_SPACE};
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ALPHABET: cfg_url = val;
			CFG_PADDING:  cfg_need_pad = val;
			CFG_STRICT:   cfg_strict = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Stops pushing and lets every predicted word drain.
	task automatic drain();
		@(negedge clk);
		push = 1'b0;
		while (pending_words.size() > 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Receiver side: random pops, a calm stretch, and one long hold-off.
	always @(negedge clk) begin
		if (!arst_n) begin
			pop = 1'b0;
		end else begin
			if (hold_asks != hold_done) begin
				hold_done = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				pop = 1'b0;
				hold_left--;
			end else if (calm) begin
				pop = 1'b1;
			end else begin
				pop = $urandom_range(0, 99) >= IDLE_PCT;
			end
		end
	end

	// Result check and stall watchdog.
	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end else if (pop && !empty) begin
				n_words++;
				if (pending_words.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("Unexpected word: st=%0b data=%02h ok=%0b last=%0b",
							is_status, data_byte, decode_ok, last_of_run);
				end else begin
					exp_w = pending_words.pop_front();
					if (is_status !== exp_w.st || data_byte !== exp_w.data ||
							decode_ok !== exp_w.ok || last_of_run !== exp_w.last) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("Mismatch: exp st=%0b data=%02h ok=%0b last=%0b, %s",
								exp_w.st, exp_w.data, exp_w.ok, exp_w.last,
								$sformatf("got st=%0b data=%02h ok=%0b last=%0b",
								is_status, data_byte, decode_ok, last_of_run));
					end
				end
			end
		end
	end

	// Main sequence.
	initial begin
		dir_row_t   dir_rows[26];
		logic [2:0] settings[8];
		int         phase_start;
		int         roll;
		cfg_url = 1'b0;
		cfg_need_pad = 1'b0;
		cfg_strict = 1'b0;
		clear_string();
		dir_rows = '{
			'{8'h3D, 1'b1, 1'b1, 1'b0},	// padding as the first character
			'{8'h20, 1'b1, 1'b1, 1'b1},	// whitespace-only string
			'{8'h2F, 1'b0, 1'b0, 1'b0},	// "////" gives all-ones bytes
			'{8'h2F, 1'b0, 1'b0, 1'b0},
			'{8'h2F, 1'b0, 1'b0, 1'b0},
			'{8'h2F, 1'b0, 1'b0, 1'b0},
			'{8'h5A, 1'b0, 1'b0, 1'b0},	// "Zm9" ends with a tail of three
			'{8'h6D, 1'b0, 1'b0, 1'b0},
			'{8'h39, 1'b1, 1'b0, 1'b0},
			'{8'h00, 1'b1, 1'b1, 1'b0},	// lowest byte is invalid
			'{8'hFF, 1'b1, 1'b1, 1'b0},	// highest byte is invalid
			'{8'h51, 1'b0, 1'b0, 1'b0},	// padding in second place
			'{8'h3D, 1'b0, 1'b0, 1'b0},
			'{8'h41, 1'b1, 1'b1, 1'b0},	// absorbed after the failure
			'{8'h41, 1'b0, 1'b0, 1'b0},	// "AB=C" is broken padding
			'{8'h42, 1'b0, 1'b0, 1'b0},
			'{8'h3D, 1'b0, 1'b0, 1'b0},
			'{8'h43, 1'b1, 1'b1, 1'b0},
			'{8'h5A, 1'b0, 1'b0, 1'b0},	// "Zg==" is a proper padded quad
			'{8'h67, 1'b0, 1'b0, 1'b0},
			'{8'h3D, 1'b0, 1'b0, 1'b0},
			'{8'h3D, 1'b0, 1'b0, 1'b0},
			'{8'h41, 1'b1, 1'b1, 1'b0},	// data after the padded quad
			'{8'h51, 1'b1, 1'b1, 1'b0},	// tail of one character
			'{8'h51, 1'b0, 1'b0, 1'b0},	// "QQ" ends with a tail of two
			'{8'h51, 1'b1, 1'b0, 1'b0}
		};
		// Register settings as {strict, padding, alphabet}.
		settings = '{3'b000, 3'b111, 3'b010, 3'b101, 3'b100, 3'b011, 3'b001, 3'b110};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table under the reset settings.
		foreach (dir_rows[i])
			send_char(dir_rows[i].chr, dir_rows[i].eos, dir_rows[i].typed, dir_rows[i].ok);
		drain();

		// Random strings under each register setting.
		foreach (settings[p]) begin
			write_reg(CFG_ALPHABET, settings[p][0]);
			write_reg(CFG_PADDING, settings[p][1]);
			write_reg(CFG_STRICT, settings[p][2]);
			n_settings++;
			calm = (p == 2);
			// Receiver holds off while long strings keep coming.
			if (p == 1) begin
				hold_asks++;
				for (int k = 0; k < 4; k++) begin
					build_encoded(6, 1'b1, 0);
					send_string();
				end
			end
			phase_start = n_chars;
			while (n_chars - phase_start < PHASE_CHARS) begin
				roll = $urandom_range(0, 99);
				if (roll < 85) begin
					build_encoded($urandom_range(0, 6),
						cfg_need_pad ? 1'b1 : 1'($urandom_range(0, 1)),
						$urandom_range(0, 1) ? 10 : 0);
					// Corrupt one character with a random byte.
					if (roll >= 70)
						str_chars[$urandom_range(0, str_chars.size() - 1)] =
							8'($urandom_range(0, 255));
				end else begin
					str_chars.delete();
					repeat ($urandom_range(1, 5))
						str_chars = {str_chars, 8'($urandom_range(0, 255))};
				end
				send_string();
			end
			drain();
			calm = 1'b0;
		end

		// Everything predicted must have arrived.
		if (pending_words.size() > 0) begin
			errors++;
			$display("%0d predicted words never arrived", pending_words.size());
		end
		$display("Decoded %0d strings (%0d failed) from %0d characters into %0d words,",
			n_strings, n_bad_strings, n_chars, n_words);
		$display("under reset values and %0d register settings.", n_settings);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
